[rtl/core/drrip_deadblock_replacement_defines.svh]
// Assertion macros for the DRRIP dead-block replacement engine.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef DRRIP_DEADBLOCK_REPLACEMENT_DEFINES_SVH
`define DRRIP_DEADBLOCK_REPLACEMENT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// antecedent implies consequent in the same cycle
`define DRD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// antecedent implies consequent in the next cycle
`define DRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DRD_ASSERT_NOW(lbl, ante, cons, msg)
`define DRD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[rtl/core/drd_pkg.sv]
// Shared types and constants for the DRRIP dead-block replacement engine.
// No dependencies.
package drd_pkg;

  localparam int NUM_SETS_DEF   = 2048;
  localparam int NUM_WAYS_DEF   = 16;
  localparam int LEADERS_DEF    = 64;
  localparam int QUEUE_DEPTH    = 2;
  localparam int MASK_WAYS      = 16;

  localparam logic [19:0] DECAY_RESET = 20'd100000;
  localparam logic [9:0]  PSEL_MID    = 10'd512;
  localparam logic [9:0]  PSEL_MAX    = 10'd1023;
  localparam logic [1:0]  RRPV_MAX    = 2'd3;
  localparam logic [1:0]  RRPV_LONG   = 2'd2;
  localparam logic [1:0]  DEAD_INIT   = 2'd1;

  // leader classes
  localparam logic [1:0] LDR_NONE  = 2'd0;
  localparam logic [1:0] LDR_SRRIP = 2'd1;
  localparam logic [1:0] LDR_BRRIP = 2'd2;

  // request kinds
  localparam logic KIND_VICTIM = 1'b0;
  localparam logic KIND_UPDATE = 1'b1;

  // result sources
  localparam logic [1:0] SRC_INVALID = 2'd0;
  localparam logic [1:0] SRC_DEAD    = 2'd1;
  localparam logic [1:0] SRC_RRPV    = 2'd2;
  localparam logic [1:0] SRC_UPDATE  = 2'd3;

  typedef struct packed {
    logic        kind;
    logic [10:0] set_index;
    logic [3:0]  way_index;
    logic        hit_flag;
    logic [15:0] valid_mask;
    logic [3:0]  random_nibble;
  } drd_in_t;

  typedef struct packed {
    logic [3:0] victim_way;
    logic [1:0] victim_source;
  } drd_out_t;

  // classified request between front and back
  typedef struct packed {
    logic        kind;
    logic [10:0] set_idx;
    logic [3:0]  way_idx;
    logic        hit;
    logic [3:0]  rnd;
    logic        has_inv;
    logic [3:0]  inv_way;
  } drd_cmd_t;

  // back-end status seen by the front
  typedef struct packed {
    logic clearing;
  } drd_stat_t;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_LOOK,
    ST_FIN,
    ST_DRD,
    ST_DWR
  } drd_state_t;

endpackage

[rtl/core/drd_front.sv]
// Front end: accepts requests, reduces set and way, finds the first invalid way.
// Depends on drd_pkg.
module drd_front #(
  parameter int NUM_SETS = drd_pkg::NUM_SETS_DEF,
  parameter int NUM_WAYS = drd_pkg::NUM_WAYS_DEF
) (
  input  logic                in_valid,
  output logic                in_ready,
  input  drd_pkg::drd_in_t    in_data,
  input  drd_pkg::drd_stat_t  stat,
  output logic                push,
  output drd_pkg::drd_cmd_t   push_cmd,
  input  logic                q_ready
);
  import drd_pkg::*;

  localparam int INV_WAYS = (NUM_WAYS < MASK_WAYS) ? NUM_WAYS : MASK_WAYS;

  // no requests during the clearing pass
  assign in_ready = q_ready & ~stat.clearing;
  assign push     = in_valid & in_ready;

  always_comb begin
    logic [10:0] s;
    logic [3:0]  w;
    logic        f;
    logic [3:0]  fw;
    s = in_data.set_index;
    w = in_data.way_index;
    // restoring reduction modulo set and way counts
    for (int k = 3; k >= 0; k--) begin
      if (int'(s) >= (NUM_SETS << k)) s = s - 11'(NUM_SETS << k);
      if (int'(w) >= (NUM_WAYS << k)) w = w - 4'(NUM_WAYS << k);
    end
    // lowest invalid way covered by the mask
    f  = 1'b0;
    fw = '0;
    for (int i = INV_WAYS - 1; i >= 0; i--) begin
      if (!in_data.valid_mask[i]) begin
        f  = 1'b1;
        fw = 4'(i);
      end
    end
    push_cmd.kind    = in_data.kind;
    push_cmd.set_idx = s;
    push_cmd.way_idx = w;
    push_cmd.hit     = in_data.hit_flag;
    push_cmd.rnd     = in_data.random_nibble;
    push_cmd.has_inv = f;
    push_cmd.inv_way = fw;
  end

endmodule

[rtl/core/drd_queue.sv]
// Short request queue between front and back end.
// Depends on drd_pkg.
module drd_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  drd_pkg::drd_cmd_t  push_cmd,
  output logic               q_ready,
  input  logic               pop,
  output logic               q_valid,
  output drd_pkg::drd_cmd_t  head
);
  import drd_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  drd_cmd_t          slot_r [QUEUE_DEPTH];
  logic [PW-1:0]     wp_r, rp_r;
  logic [PW:0]       cnt_r;

  assign q_ready = (cnt_r != (PW+1)'(QUEUE_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign head    = slot_r[rp_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= push_cmd;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule

[rtl/core/drd_back.sv]
// Back end: set-state memory, victim selection, updates, decay and clearing sweeps.
// Depends on drd_pkg.
module drd_back #(
  parameter int NUM_SETS           = drd_pkg::NUM_SETS_DEF,
  parameter int NUM_WAYS           = drd_pkg::NUM_WAYS_DEF,
  parameter int LEADERS_PER_POLICY = drd_pkg::LEADERS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  drd_pkg::drd_cmd_t   head,
  output logic                pop,
  output drd_pkg::drd_stat_t  stat,
  input  logic                cfg_we,
  input  logic [19:0]         cfg_wdata,
  output logic                out_valid,
  input  logic                out_ready,
  output drd_pkg::drd_out_t   out_data
);
  import drd_pkg::*;

  localparam int SW    = $clog2(NUM_SETS);
  localparam int WW    = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int RW    = 4 * NUM_WAYS + 2;
  localparam int DB    = 2 * NUM_WAYS;          // dead counter field base
  localparam int LB    = 4 * NUM_WAYS;          // leader field base
  localparam int LSPAN = 2 * LEADERS_PER_POLICY;
  localparam int LQ    = NUM_SETS / LSPAN;
  localparam int LR    = NUM_SETS % LSPAN;
  localparam int LIW   = $clog2(LSPAN + 1);
  localparam int LRW   = $clog2(LSPAN) + 1;

  // set-state memory: one row per set
  logic [RW-1:0] mem [NUM_SETS];
  logic [RW-1:0] rd_data_r;
  logic          mem_we;
  logic [SW-1:0] mem_wa, mem_ra;
  logic [RW-1:0] mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_data_r <= mem[mem_ra];
  end

  drd_state_t    state_r, state_nxt;
  drd_cmd_t      cmd_r;
  logic [SW-1:0] sweep_r, sweep_nxt;
  logic [LIW-1:0] ldr_i_r, ldr_i_nxt;
  logic [SW:0]   ldr_t_r, ldr_t_nxt;
  logic [LRW-1:0] ldr_rem_r, ldr_rem_nxt;
  logic [1:0]    ldr_acc_r, ldr_acc_nxt;
  logic [9:0]    psel_r, psel_nxt;
  logic [19:0]   cnt_r, cnt_nxt;
  logic [19:0]   period_r;
  logic          dead_f_r, dead_f_nxt;
  logic [WW-1:0] dead_w_r, dead_w_nxt;
  logic [1:0]    top_r, top_nxt;
  logic [WW-1:0] max_w_r, max_w_nxt;
  logic          out_valid_r, out_valid_nxt;
  drd_out_t      out_r, out_nxt;

  logic          ldr_hit, clr_last, sweep_last, dec_now;
  logic [19:0]   cnt_inc;
  logic [SW-1:0] cmd_set;

  assign cmd_set    = SW'(cmd_r.set_idx);
  assign ldr_hit    = (int'(ldr_i_r) < LSPAN) && (ldr_t_r == {1'b0, sweep_r});
  assign sweep_last = (sweep_r == SW'(NUM_SETS - 1));
  assign clr_last   = !ldr_hit && sweep_last;
  assign cnt_inc    = cnt_r + 20'd1;
  assign dec_now    = (cnt_inc >= period_r);
  assign pop        = (state_r == ST_IDLE) && q_valid && !out_valid_r;
  assign stat.clearing = (state_r == ST_CLR);
  assign out_valid  = out_valid_r;
  assign out_data   = out_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLR:  if (clr_last) state_nxt = ST_IDLE;
      ST_IDLE: if (pop) state_nxt = ST_LOOK;
      ST_LOOK: begin
        if (cmd_r.kind == KIND_VICTIM) state_nxt = ST_FIN;
        else if (dec_now)              state_nxt = ST_DRD;
        else                           state_nxt = ST_IDLE;
      end
      ST_FIN:  state_nxt = ST_IDLE;
      ST_DRD:  state_nxt = ST_DWR;
      ST_DWR:  state_nxt = sweep_last ? ST_IDLE : ST_DRD;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    logic [RW-1:0] row;
    logic [1:0]    rv, dv;
    logic          any3, any2, any1;
    logic          srrip;
    logic [1:0]    add;
    mem_we      = 1'b0;
    mem_wa      = cmd_set;
    mem_wd      = rd_data_r;
    mem_ra      = cmd_set;
    sweep_nxt   = sweep_r;
    ldr_i_nxt   = ldr_i_r;
    ldr_t_nxt   = ldr_t_r;
    ldr_rem_nxt = ldr_rem_r;
    ldr_acc_nxt = ldr_acc_r;
    psel_nxt    = psel_r;
    cnt_nxt     = cnt_r;
    dead_f_nxt  = dead_f_r;
    dead_w_nxt  = dead_w_r;
    top_nxt     = top_r;
    max_w_nxt   = max_w_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_nxt     = out_r;
    row         = rd_data_r;
    rv          = '0;
    dv          = '0;
    any3        = 1'b0;
    any2        = 1'b0;
    any1        = 1'b0;
    srrip       = 1'b0;
    add         = RRPV_MAX - top_r;
    unique case (state_r)
      // clearing pass; leader sets found by stepping floor(i*N/span)
      ST_CLR: begin
        if (ldr_hit) begin
          ldr_acc_nxt = (int'(ldr_i_r) >= LEADERS_PER_POLICY) ? LDR_BRRIP :
                        ((ldr_acc_r == LDR_BRRIP) ? LDR_BRRIP : LDR_SRRIP);
          ldr_i_nxt = ldr_i_r + 1'b1;
          if (int'(ldr_rem_r) + LR >= LSPAN) begin
            ldr_rem_nxt = LRW'(int'(ldr_rem_r) + LR - LSPAN);
            ldr_t_nxt   = ldr_t_r + (SW+1)'(LQ + 1);
          end else begin
            ldr_rem_nxt = LRW'(int'(ldr_rem_r) + LR);
            ldr_t_nxt   = ldr_t_r + (SW+1)'(LQ);
          end
        end else begin
          for (int w = 0; w < NUM_WAYS; w++) begin
            row[2*w +: 2]      = RRPV_LONG;
            row[DB + 2*w +: 2] = DEAD_INIT;
          end
          row[LB +: 2] = ldr_acc_r;
          mem_we      = 1'b1;
          mem_wa      = sweep_r;
          mem_wd      = row;
          ldr_acc_nxt = LDR_NONE;
          sweep_nxt   = sweep_last ? '0 : sweep_r + 1'b1;
        end
      end
      ST_IDLE: mem_ra = SW'(head.set_idx);
      ST_LOOK: begin
        if (cmd_r.kind == KIND_VICTIM) begin
          // dead-way search and RRPV maximum
          dead_f_nxt = 1'b0;
          dead_w_nxt = '0;
          for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (rd_data_r[DB + 2*w +: 2] == 2'd0) begin
              dead_f_nxt = 1'b1;
              dead_w_nxt = WW'(w);
            end
            any3 = any3 | (rd_data_r[2*w +: 2] == 2'd3);
            any2 = any2 | (rd_data_r[2*w +: 2] == 2'd2);
            any1 = any1 | (rd_data_r[2*w +: 2] == 2'd1);
          end
          top_nxt = any3 ? 2'd3 : (any2 ? 2'd2 : (any1 ? 2'd1 : 2'd0));
          max_w_nxt = '0;
          for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (rd_data_r[2*w +: 2] == top_nxt) max_w_nxt = WW'(w);
          end
        end else begin
          // state update for one way
          rv = rd_data_r[2*cmd_r.way_idx +: 2];
          dv = rd_data_r[DB + 2*cmd_r.way_idx +: 2];
          srrip = (rd_data_r[LB +: 2] != LDR_NONE) ? (rd_data_r[LB +: 2] == LDR_SRRIP)
                                                  : (psel_r >= PSEL_MID);
          if (cmd_r.hit) begin
            if (dv != 2'd3) dv = dv + 2'd1;
            rv = 2'd0;
            if (rd_data_r[LB +: 2] == LDR_SRRIP && psel_r != PSEL_MAX)
              psel_nxt = psel_r + 10'd1;
            else if (rd_data_r[LB +: 2] == LDR_BRRIP && psel_r != 10'd0)
              psel_nxt = psel_r - 10'd1;
          end else begin
            if (dv != 2'd0) dv = dv - 2'd1;
            rv = (srrip || cmd_r.rnd == 4'd0) ? RRPV_LONG : RRPV_MAX;
          end
          row[2*cmd_r.way_idx +: 2]      = rv;
          row[DB + 2*cmd_r.way_idx +: 2] = dv;
          mem_we  = 1'b1;
          mem_wd  = row;
          cnt_nxt = dec_now ? 20'd0 : cnt_inc;
          sweep_nxt = '0;
          out_valid_nxt = 1'b1;
          out_nxt.victim_way    = 4'd0;
          out_nxt.victim_source = SRC_UPDATE;
        end
      end
      ST_FIN: begin
        out_valid_nxt = 1'b1;
        if (cmd_r.has_inv) begin
          out_nxt.victim_way    = cmd_r.inv_way;
          out_nxt.victim_source = SRC_INVALID;
        end else if (dead_f_r) begin
          out_nxt.victim_way    = 4'(dead_w_r);
          out_nxt.victim_source = SRC_DEAD;
        end else begin
          out_nxt.victim_way    = 4'(max_w_r);
          out_nxt.victim_source = SRC_RRPV;
          // age the set so the largest RRPV reaches the maximum
          if (top_r != RRPV_MAX) begin
            for (int w = 0; w < NUM_WAYS; w++) row[2*w +: 2] = rd_data_r[2*w +: 2] + add;
            mem_we = 1'b1;
            mem_wd = row;
          end
        end
      end
      ST_DRD: mem_ra = sweep_r;
      ST_DWR: begin
        // global dead counter decay, one row
        for (int w = 0; w < NUM_WAYS; w++) begin
          if (rd_data_r[DB + 2*w +: 2] != 2'd0)
            row[DB + 2*w +: 2] = rd_data_r[DB + 2*w +: 2] - 2'd1;
        end
        mem_we    = 1'b1;
        mem_wa    = sweep_r;
        mem_wd    = row;
        mem_ra    = sweep_r;
        sweep_nxt = sweep_last ? '0 : sweep_r + 1'b1;
      end
      default: ;
    endcase
  end

  // request capture and payload registers
  always_ff @(posedge clk) begin
    if (pop) cmd_r <= head;
    dead_f_r <= dead_f_nxt;
    dead_w_r <= dead_w_nxt;
    top_r    <= top_nxt;
    max_w_r  <= max_w_nxt;
    out_r    <= out_nxt;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      sweep_r     <= '0;
      ldr_i_r     <= '0;
      ldr_t_r     <= '0;
      ldr_rem_r   <= '0;
      ldr_acc_r   <= LDR_NONE;
      psel_r      <= PSEL_MID;
      cnt_r       <= '0;
      period_r    <= DECAY_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      ldr_i_r     <= ldr_i_nxt;
      ldr_t_r     <= ldr_t_nxt;
      ldr_rem_r   <= ldr_rem_nxt;
      ldr_acc_r   <= ldr_acc_nxt;
      psel_r      <= psel_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) period_r <= cfg_wdata;
    end
  end

endmodule

[rtl/core/drrip_deadblock_replacement.sv]
// Top level of the DRRIP dead-block replacement engine: front, queue, back.
// Depends on drd_pkg, drd_front, drd_queue, drd_back and the defines header.
//
//   channel  ports                            moves
//   in       in_valid, in_ready, in_data      one request
//   out      out_valid, out_ready, out_data   one result per request
//   cfg      cfg_we, cfg_wdata                decay period write
//
// The back end takes one request at a time: a victim request passes memory read, lookup,
// finish and result taken, an update memory read, lookup and write, and result taken.
// The next pop waits until the result has been taken.
// After reset a clearing pass writes every set row; no request is accepted during it.
// Every decay period, an update is followed by a decay sweep over every set row.
// The two-entry queue keeps accepting, until full, while the back end works or the
// output stalls.
`include "drrip_deadblock_replacement_defines.svh"
module drrip_deadblock_replacement #(
  parameter int NUM_SETS           = drd_pkg::NUM_SETS_DEF,
  parameter int NUM_WAYS           = drd_pkg::NUM_WAYS_DEF,
  parameter int LEADERS_PER_POLICY = drd_pkg::LEADERS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  drd_pkg::drd_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output drd_pkg::drd_out_t  out_data,
  input  logic               cfg_we,
  input  logic [19:0]        cfg_wdata
);
  import drd_pkg::*;

  logic      push, q_ready, pop, q_valid;
  drd_cmd_t  push_cmd, head;
  drd_stat_t stat;

  drd_front #(.NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS)) u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .stat     (stat),
    .push     (push),
    .push_cmd (push_cmd),
    .q_ready  (q_ready)
  );

  drd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .q_ready  (q_ready),
    .pop      (pop),
    .q_valid  (q_valid),
    .head     (head)
  );

  drd_back #(
    .NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS), .LEADERS_PER_POLICY(LEADERS_PER_POLICY)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .head      (head),
    .pop       (pop),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // assertions
  `DRD_ASSERT_NOW(a_no_accept_clear, stat.clearing, !in_ready, "request taken while clearing")
  `DRD_ASSERT_NOW(a_upd_way_zero, out_valid && out_data.victim_source == SRC_UPDATE, out_data.victim_way == 4'd0, "update ack with nonzero way")
  `DRD_ASSERT_NOW(a_pop_needs_data, pop, q_valid, "pop from empty queue")
  `DRD_ASSERT_NEXT(a_push_fills, push && !pop, q_valid, "queue empty after push")

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the DRRIP dead-block replacement engine.
// Needs drd_pkg and drrip_deadblock_replacement; it predicts each result from its own copy of the state.
`timescale 1ns / 100ps
module testbench;
  import drd_pkg::*;

  localparam int SETS       = NUM_SETS_DEF;
  localparam int WAYS       = NUM_WAYS_DEF;
  localparam int LEADERS    = LEADERS_DEF;
  // margin for a decay sweep over every set, plus the back end and queue
  localparam int SETTLE     = 2 * SETS + 200;
  localparam int CYCLE_LIMIT = 4000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  drd_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  drd_out_t    out_data;
  logic        cfg_we = 1'b0;
  logic [19:0] cfg_wdata = '0;

  drrip_deadblock_replacement dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // predicted replacement state
  logic [1:0]  rrpv_mem [0:SETS*WAYS-1];
  logic [1:0]  dead_mem [0:SETS*WAYS-1];
  logic [1:0]  leader_cls [0:SETS-1];
  logic [9:0]  psel;
  logic [19:0] upd_count;
  logic [19:0] decay_len;

  drd_out_t    pending_results [$];
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          n_errors = 0;
  int          n_requests = 0;
  int          n_results = 0;
  int          n_decays = 0;
  int          cycles = 0;

  // pick a victim or apply an update, mirroring the engine's rules
  function automatic drd_out_t predict_result(input drd_in_t r);
    drd_out_t res;
    int base, idx, w, top;
    logic [1:0] cls;
    logic srrip;
    res = '0;
    base = int'(r.set_index) * WAYS;
    if (r.kind == KIND_VICTIM) begin
      for (w = WAYS - 1; w >= 0; w--)
        if (!r.valid_mask[w]) begin
          res.victim_way = w[3:0];
          res.victim_source = SRC_INVALID;
        end
      if (&r.valid_mask) begin
        res.victim_source = SRC_RRPV;
        for (w = WAYS - 1; w >= 0; w--)
          if (dead_mem[base + w] == 2'd0) begin
            res.victim_way = w[3:0];
            res.victim_source = SRC_DEAD;
          end
        if (res.victim_source == SRC_RRPV) begin
          top = 0;
          for (w = 0; w < WAYS; w++)
            if (int'(rrpv_mem[base + w]) > top) top = int'(rrpv_mem[base + w]);
          for (w = 0; w < WAYS; w++)
            rrpv_mem[base + w] = rrpv_mem[base + w] + 2'(int'(RRPV_MAX) - top);
          for (w = WAYS - 1; w >= 0; w--)
            if (rrpv_mem[base + w] == RRPV_MAX) res.victim_way = w[3:0];
        end
      end
    end else begin
      idx = base + int'(r.way_index);
      cls = leader_cls[r.set_index];
      srrip = (cls != LDR_NONE) ? (cls == LDR_SRRIP) : (psel >= PSEL_MID);
      if (r.hit_flag) begin
        if (dead_mem[idx] != 2'd3) dead_mem[idx]++;
        rrpv_mem[idx] = 2'd0;
        if (cls == LDR_SRRIP && psel != PSEL_MAX) psel++;
        else if (cls == LDR_BRRIP && psel != 10'd0) psel--;
      end else begin
        if (dead_mem[idx] != 2'd0) dead_mem[idx]--;
        rrpv_mem[idx] = (srrip || r.random_nibble == 4'd0) ? RRPV_LONG : RRPV_MAX;
      end
      upd_count = upd_count + 20'd1;
      if (upd_count >= decay_len) begin
        upd_count = '0;
        n_decays++;
        for (idx = 0; idx < SETS * WAYS; idx++)
          if (dead_mem[idx] != 2'd0) dead_mem[idx]--;
      end
      res.victim_source = SRC_UPDATE;
    end
    return res;
  endfunction

  // send one request, predict on acceptance
  task automatic send_request(input drd_in_t r);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_result(r));
    n_requests++;
  endtask

  function automatic drd_in_t make_update(input int set, input int way, input logic hit,
                                          input logic [3:0] nib);
    drd_in_t r;
    r = '0;
    r.kind = KIND_UPDATE;
    r.set_index = set[10:0];
    r.way_index = way[3:0];
    r.hit_flag = hit;
    r.random_nibble = nib;
    r.valid_mask = 16'($urandom);
    return r;
  endfunction

  function automatic drd_in_t make_victim(input int set, input logic [15:0] mask);
    drd_in_t r;
    r = '0;
    r.kind = KIND_VICTIM;
    r.set_index = set[10:0];
    r.valid_mask = mask;
    r.way_index = 4'($urandom);
    r.hit_flag = 1'($urandom);
    r.random_nibble = 4'($urandom);
    return r;
  endfunction

  // wait for every result, then for a possible decay sweep
  task automatic drain_engine();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_decay_period(input logic [19:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    decay_len = v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    drd_out_t want;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: way %0d source %0d",
               out_data.victim_way, out_data.victim_source);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.victim_way !== want.victim_way) begin
          $error("victim_way expected %0d got %0d", want.victim_way, out_data.victim_way);
          n_errors++;
        end
        if (out_data.victim_source !== want.victim_source) begin
          $error("victim_source expected %0d got %0d",
                 want.victim_source, out_data.victim_source);
          n_errors++;
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk)
    out_ready <= ($urandom_range(0, 99) >= stall_pct);

  // cycle watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // extremes of every field and each selection path
  task automatic test_directed();
    send_request(make_victim(5, 16'h0000));
    send_request(make_victim(5, 16'h7FFF));
    send_request(make_victim(5, 16'hFFFE));
    send_request(make_victim(5, 16'hFFFF));      // everything ages to 3
    send_request(make_victim(5, 16'hFFFF));
    send_request(make_update(3, 5, 1'b0, 4'hF)); // miss: dead counter to 0
    send_request(make_victim(3, 16'hFFFF));      // dead block chosen
    send_request(make_victim(3, 16'hFFDF));      // invalid beats dead
    send_request(make_update(3, 5, 1'b1, 4'h0));
    send_request(make_victim(3, 16'hFFFF));
    send_request(make_update(2047, 15, 1'b1, 4'hF));
    send_request(make_update(2047, 15, 1'b0, 4'h0));
    send_request(make_update(2047, 14, 1'b0, 4'h0));
    send_request(make_victim(2047, 16'hFFFF));
    send_request(make_update(1024, 0, 1'b0, 4'h0)); // BRRIP leader, nibble zero
    send_request(make_update(1024, 1, 1'b0, 4'h7)); // BRRIP leader, nibble nonzero
    send_request(make_update(0, 2, 1'b0, 4'h7));    // SRRIP leader
    send_request(make_update(0, 2, 1'b1, 4'h7));
    send_request(make_update(1024, 1, 1'b1, 4'h7));
    send_request(make_victim(1024, 16'hFFFF));
    send_request(make_victim(0, 16'hFFFF));
    send_request(make_victim(1024, 16'hFFFF));
    drain_engine();
  endtask

  // global decay at the shortest and longest periods
  task automatic test_decay();
    int i;
    write_decay_period(20'd1);
    for (i = 0; i < 6; i++) begin
      send_request(make_update(9, i, 1'b1, 4'($urandom)));
      send_request(make_victim(9, 16'hFFFF));
    end
    drain_engine();
    write_decay_period(20'hFFFFF);
    for (i = 0; i < 6; i++) begin
      send_request(make_update(9, i + 8, 1'b0, 4'($urandom)));
      send_request(make_victim(9, 16'hFFFF));
    end
    drain_engine();
  endtask

  // push the selector below the midpoint, then back above it
  task automatic test_selector_sweep();
    int i;
    for (i = 0; i < 24; i++)
      send_request(make_update(1024 + 16 * $urandom_range(0, 63), $urandom_range(0, 15),
                               1'b1, 4'($urandom)));
    for (i = 0; i < 8; i++)
      send_request(make_update(100 + i, i, 1'b0, 4'($urandom_range(0, 1))));
    for (i = 0; i < 48; i++)
      send_request(make_update(16 * $urandom_range(0, 63), $urandom_range(0, 15),
                               1'b1, 4'($urandom)));
    for (i = 0; i < 8; i++)
      send_request(make_update(100 + i, i + 8, 1'b0, 4'($urandom)));
    drain_engine();
  endtask

  // mostly traffic on a few hot sets, some fully random requests
  task automatic test_random(input int count);
    int i, set;
    logic [15:0] mask;
    int hot [8] = '{0, 16, 1024, 1040, 7, 300, 1500, 2047};
    for (i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 80) begin
        set = hot[$urandom_range(0, 7)];
        if ($urandom_range(0, 1)) begin
          mask = ($urandom_range(0, 99) < 75) ? 16'hFFFF
                 : 16'($urandom) | 16'($urandom) | 16'($urandom);
          send_request(make_victim(set, mask));
        end else begin
          send_request(make_update(set, $urandom_range(0, 15), 1'($urandom),
                                   ($urandom_range(0, 2) == 0) ? 4'h0 : 4'($urandom)));
        end
      end else begin
        send_request(drd_in_t'($bits(drd_in_t)'({$urandom, $urandom})));
      end
    end
  endtask

  initial begin
    int p;
    for (p = 0; p < SETS * WAYS; p++) begin
      rrpv_mem[p] = RRPV_LONG;
      dead_mem[p] = DEAD_INIT;
    end
    for (p = 0; p < SETS; p++) leader_cls[p] = LDR_NONE;
    for (p = 0; p < LEADERS; p++) begin
      leader_cls[p * SETS / (2 * LEADERS)] = LDR_SRRIP;
    end
    for (p = 0; p < LEADERS; p++) begin
      leader_cls[(p + LEADERS) * SETS / (2 * LEADERS)] = LDR_BRRIP;
    end
    psel = PSEL_MID;
    upd_count = '0;
    decay_len = DECAY_RESET;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_decay();
    test_selector_sweep();

    // random traffic under each idling pattern and decay setting
    write_decay_period(20'd7);
    idle_pct = 0;  stall_pct = 0;  test_random(130);
    idle_pct = 59; stall_pct = 0;  test_random(130);
    drain_engine();
    write_decay_period(20'd50);
    idle_pct = 0;  stall_pct = 59; test_random(130);
    idle_pct = 10; stall_pct = 10; test_random(130);
    drain_engine();

    $display("%0d requests sent, %0d results checked, %0d global decays predicted",
             n_requests, n_results, n_decays);
    $display("covered invalid/dead/aged victims, both insertion policies, selector crossings");
    if (n_errors == 0 && pending_results.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // leftover expectations count as failures
  always @(posedge clk)
    if (pending_results.size() != 0 && cycles == CYCLE_LIMIT) n_errors <= n_errors + 1;

endmodule
